### hw/rtl/assert_macros.svh
// Assertion macros used by the queue store control RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dsq_pkg.sv
// Types and constants of the two-queue shared store
`default_nettype none

package dsq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        REQ_ENQ_ONE = 2'd0,
        REQ_DEQ_ONE = 2'd1,
        REQ_ENQ_TWO = 2'd2,
        REQ_DEQ_TWO = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_UPPER,
        CELL_TAKE_LOWER
    } t_cell_op;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                     fire;
        t_req_type                req;
        logic [CNT_W-1:0]         count_one;
        logic [CNT_W-1:0]         count_two;
        logic signed [WORD_W-1:0] push_value;
    } t_cell_cmd;

endpackage

`default_nettype wire

### hw/rtl/dsq_req_if.sv
// Request channel: valid/ready handshake with request payload
`default_nettype none

interface dsq_req_if;
    import dsq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/dsq_res_if.sv
// Result channel: valid/ready handshake with result payload
`default_nettype none

interface dsq_res_if;
    import dsq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy_one;
    logic [OCC_W-1:0]         occupancy_two;

    modport source (output valid, output pop_value, output status,
                    output occupancy_one, output occupancy_two, input ready);
    modport sink   (input valid, input pop_value, input status,
                    input occupancy_one, input occupancy_two, output ready);
endinterface

`default_nettype wire

### hw/rtl/dsq_cell.sv
// One storage cell of the shared chain: hold, load or take a neighbour's word
`default_nettype none

module dsq_cell
    import dsq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [IDX_W-1:0]         i_index,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic signed [WORD_W-1:0] i_upper,
    input  wire logic signed [WORD_W-1:0] i_lower,
    output      logic signed [WORD_W-1:0] o_word
);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic [SUM_W-1:0]         w_idx;
    logic [SUM_W-1:0]         w_c1;
    logic [SUM_W-1:0]         w_c2;
    t_cell_op                 w_op;

    assign w_idx = SUM_W'(i_index);
    assign w_c1  = SUM_W'(i_cmd.count_one);
    assign w_c2  = SUM_W'(i_cmd.count_two);

    // Decide this cell's move from its place relative to both queues
    always_comb begin
        w_op = CELL_HOLD;
        if (i_cmd.fire) begin
            case (i_cmd.req)
                REQ_ENQ_ONE: begin
                    if (w_idx == w_c1) w_op = CELL_LOAD;
                end
                REQ_DEQ_ONE: begin
                    if ((w_idx + SUM_W'(1)) < w_c1) w_op = CELL_TAKE_UPPER;
                end
                REQ_ENQ_TWO: begin
                    if ((w_idx + w_c2) == SUM_W'(DEPTH - 1)) w_op = CELL_LOAD;
                end
                REQ_DEQ_TWO: begin
                    if ((w_idx + w_c2) > SUM_W'(DEPTH)) w_op = CELL_TAKE_LOWER;
                end
                default: w_op = CELL_HOLD;
            endcase
        end
    end

    always_comb begin
        case (w_op)
            CELL_LOAD:       n_word = i_cmd.push_value;
            CELL_TAKE_UPPER: n_word = i_upper;
            CELL_TAKE_LOWER: n_word = i_lower;
            default:         n_word = r_word;
        endcase
    end

    // Hold the word; no reset, entries are undefined until written
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

### hw/rtl/dsq_ctrl.sv
// Queue counts, request decode and registered result stage
`default_nettype none

module dsq_ctrl
    import dsq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    dsq_req_if.sink                       i_req,
    dsq_res_if.source                     o_res,
    input  wire logic signed [WORD_W-1:0] i_front_one,
    input  wire logic signed [WORD_W-1:0] i_front_two,
    output      t_cell_cmd                o_cmd
);

    logic [CNT_W-1:0]         r_count_one;
    logic [CNT_W-1:0]         r_count_two;
    logic [CNT_W-1:0]         n_count_one;
    logic [CNT_W-1:0]         n_count_two;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_pop_value;
    logic signed [WORD_W-1:0] n_pop_value;
    t_status                  r_status;
    t_status                  n_status;
    logic [OCC_W-1:0]         r_occ_one;
    logic [OCC_W-1:0]         r_occ_two;
    logic                     w_accept;
    logic                     w_full;
    t_req_type                w_req;

    assign w_req    = t_req_type'(i_req.req_type);
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = (SUM_W'(r_count_one) + SUM_W'(r_count_two)) >= SUM_W'(DEPTH);

    // Decode the request against the current counts
    always_comb begin
        n_count_one = r_count_one;
        n_count_two = r_count_two;
        n_pop_value = '0;
        n_status    = ST_OK;
        case (w_req)
            REQ_ENQ_ONE: begin
                if (w_full) n_status = ST_OVERFLOW;
                else        n_count_one = r_count_one + CNT_W'(1);
            end
            REQ_DEQ_ONE: begin
                if (r_count_one == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count_one = r_count_one - CNT_W'(1);
                    n_pop_value = i_front_one;
                end
            end
            REQ_ENQ_TWO: begin
                if (w_full) n_status = ST_OVERFLOW;
                else        n_count_two = r_count_two + CNT_W'(1);
            end
            REQ_DEQ_TWO: begin
                if (r_count_two == '0) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count_two = r_count_two - CNT_W'(1);
                    n_pop_value = i_front_two;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // Broadcast the move to the cells; only successful requests touch the store
    always_comb begin
        o_cmd.fire       = w_accept && (n_status == ST_OK);
        o_cmd.req        = w_req;
        o_cmd.count_one  = r_count_one;
        o_cmd.count_two  = r_count_two;
        o_cmd.push_value = i_req.push_value;
    end

    // Advance the counts on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_one <= '0;
            r_count_two <= '0;
        end else if (w_accept) begin
            r_count_one <= n_count_one;
            r_count_two <= n_count_two;
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value <= n_pop_value;
            r_status    <= n_status;
            r_occ_one   <= OCC_W'(n_count_one);
            r_occ_two   <= OCC_W'(n_count_two);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pop_value     = r_pop_value;
    assign o_res.status        = r_status;
    assign o_res.occupancy_one = r_occ_one;
    assign o_res.occupancy_two = r_occ_two;

`include "assert_macros.svh"

    `DSQ_ASSERT(a_store_bound, i_clk, i_rst_n, (SUM_W'(r_count_one) + SUM_W'(r_count_two)) <= SUM_W'(DEPTH), "queues exceed the store")
    `DSQ_ASSERT(a_enq_one_grows, i_clk, i_rst_n, (w_accept && (w_req == REQ_ENQ_ONE) && !w_full) |=> (r_count_one == $past(r_count_one) + CNT_W'(1)), "queue one did not grow on enqueue")
    `DSQ_ASSERT(a_fail_no_word, i_clk, i_rst_n, (r_out_valid && (r_status != ST_OK)) |-> (r_pop_value == '0), "failed request carries a word")
    `DSQ_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> ((r_count_one == '0) && (r_count_two == '0) && !r_out_valid), "reset left queue state")

endmodule

`default_nettype wire

### hw/rtl/dual_shift_queue_shared_store_unit.sv
// Top level: chain of storage cells shared by two queues, plus control
`default_nettype none

// Two FIFO queues share one row of DEPTH 32-bit cells and grow toward each
// other: queue one from cell 0 upward, queue two from the top cell downward.
// Every request (enqueue or dequeue on either queue) gives exactly one
// result with the popped word, a status (ok, overflow, underflow) and both
// occupancy counts after the request. A dequeue shifts the remaining words of
// that queue one cell toward its base, all cells moving in the same edge, so
// one item is accepted per cycle while the output register is empty or being
// read out; the result appears in the output register in the cycle after
// acceptance. Stored words are not cleared by reset; only queued words are
// ever returned.
module dual_shift_queue_shared_store_unit
    import dsq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsq_req_if.sink   i_req,
    dsq_res_if.source o_res
);

    t_cell_cmd                w_cmd;
    logic signed [WORD_W-1:0] w_word  [DEPTH];
    logic signed [WORD_W-1:0] w_upper [DEPTH];
    logic signed [WORD_W-1:0] w_lower [DEPTH];

    dsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (o_res),
        .i_front_one (w_word[0]),
        .i_front_two (w_word[DEPTH-1]),
        .o_cmd       (w_cmd)
    );

    // Wire each cell to its neighbours; end cells see their own word
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g < DEPTH - 1) begin : g_up
            assign w_upper[g] = w_word[g+1];
        end else begin : g_up_end
            assign w_upper[g] = w_word[g];
        end
        if (g > 0) begin : g_lo
            assign w_lower[g] = w_word[g-1];
        end else begin : g_lo_end
            assign w_lower[g] = w_word[g];
        end

        dsq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_upper (w_upper[g]),
            .i_lower (w_lower[g]),
            .o_word  (w_word[g])
        );
    end

endmodule

`default_nettype wire

### test/tb_dual_shift_queue_shared_store_unit.sv
// Testbench for the two-queue shared store: directed and random requests, scoreboard check
`default_nettype none

module tb_dual_shift_queue_shared_store_unit
    import dsq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT     = 5000;
    localparam int RANDOM_ITEMS   = 1490;
    localparam int PRESSURE_ITEMS = 40;
    localparam int PRESSURE_HOLD  = 300;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic signed [WORD_W-1:0] pop_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy_one;
        logic [OCC_W-1:0]         occupancy_two;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    dsq_req_if req_if ();
    dsq_res_if res_if ();

    dual_shift_queue_shared_store_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow of the shared store and both queue counts
    logic [WORD_W-1:0] shadow_store [DEPTH];
    int                words_one;
    int                words_two;

    t_queue_result pending_results[$];
    int            failure_count;
    int            burst_left;
    int            hold_request;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result of one request and advance the shadow state
    function automatic t_queue_result predict_request(input t_req_type kind,
                                                      input logic [WORD_W-1:0] word);
        t_queue_result res;
        res.pop_value = '0;
        res.status    = ST_OK;
        case (kind)
            REQ_ENQ_ONE: begin
                if (words_one + words_two >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_store[words_one] = word;
                    words_one++;
                end
            end
            REQ_DEQ_ONE: begin
                if (words_one == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.pop_value = shadow_store[0];
                    // shift the rest of queue one toward entry 0
                    for (int i = 0; i < words_one - 1; i++)
                        shadow_store[i] = shadow_store[i + 1];
                    words_one--;
                end
            end
            REQ_ENQ_TWO: begin
                if (words_one + words_two >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_store[DEPTH - 1 - words_two] = word;
                    words_two++;
                end
            end
            default: begin
                if (words_two == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.pop_value = shadow_store[DEPTH - 1];
                    // shift the rest of queue two toward the top entry
                    for (int i = 0; i < words_two - 1; i++)
                        shadow_store[DEPTH - 1 - i] = shadow_store[DEPTH - 2 - i];
                    words_two--;
                end
            end
        endcase
        res.occupancy_one = words_one[OCC_W-1:0];
        res.occupancy_two = words_two[OCC_W-1:0];
        return res;
    endfunction

    // Offer one item, idling between bursts, and record its result once accepted
    task automatic send_request(input t_req_type kind, input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30)
                                                     : $urandom_range(12, 1);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.push_value <= word;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(predict_request(kind, word));
        burst_left--;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] word;
        case ($urandom_range(15, 0))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'h0000_0000;
            3:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
        endcase
        return word;
    endfunction

    // Empty queues, extreme words, a full store with overflow, and a dequeue from each queue
    task automatic test_directed_cases();
        logic [WORD_W-1:0] extremes [4];
        extremes[0] = 32'h8000_0000;
        extremes[1] = 32'h7FFF_FFFF;
        extremes[2] = 32'h0000_0000;
        extremes[3] = 32'hFFFF_FFFF;
        send_request(REQ_DEQ_ONE, $urandom);
        send_request(REQ_DEQ_TWO, $urandom);
        // fill the store from both ends
        for (int i = 0; i < DEPTH / 2; i++) begin
            send_request(REQ_ENQ_ONE, (i < 4) ? extremes[i] : $urandom);
            send_request(REQ_ENQ_TWO, (i < 4) ? extremes[3 - i] : $urandom);
        end
        send_request(REQ_ENQ_ONE, $urandom);
        send_request(REQ_ENQ_TWO, $urandom);
        send_request(REQ_DEQ_ONE, $urandom);
        send_request(REQ_DEQ_TWO, $urandom);
    endtask

    // Hold the result side off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        hold_request = PRESSURE_HOLD;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_request(t_req_type'($urandom_range(3, 0)), pick_word());
    endtask

    // Random traffic in phases biased toward filling, draining or one queue
    task automatic test_random_traffic();
        int enq_pct;
        int one_pct;
        logic is_enq;
        logic is_one;
        enq_pct = 50;
        one_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(3, 0))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    2:       enq_pct = 65;
                    default: enq_pct = 50;
                endcase
                case ($urandom_range(2, 0))
                    0:       one_pct = 85;
                    1:       one_pct = 15;
                    default: one_pct = 50;
                endcase
            end
            is_enq = ($urandom_range(99, 0) < enq_pct);
            is_one = ($urandom_range(99, 0) < one_pct);
            if (is_enq)
                send_request(is_one ? REQ_ENQ_ONE : REQ_ENQ_TWO, pick_word());
            else
                send_request(is_one ? REQ_DEQ_ONE : REQ_DEQ_TWO, pick_word());
        end
    endtask

    // Result side: stall on a pattern that is re-picked at random, or hold off on request
    initial begin
        int hold_left;
        int pattern;
        int cycle;
        hold_left = 0;
        pattern   = 0;
        cycle     = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (cycle % 64 == 0)
                pattern = $urandom_range(3, 0);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                case (pattern)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(1, 0) == 1);
                    2:       res_if.ready <= (cycle % 4 != 0);
                    default: res_if.ready <= ($urandom_range(7, 0) != 0);
                endcase
            end
            cycle++;
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (failure_count < REPORT_LIMIT)
                    $display("unexpected result: pop %h status %0d occ %0d/%0d",
                             res_if.pop_value, res_if.status,
                             res_if.occupancy_one, res_if.occupancy_two);
                failure_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.pop_value !== want.pop_value || res_if.status !== want.status ||
                    res_if.occupancy_one !== want.occupancy_one ||
                    res_if.occupancy_two !== want.occupancy_two) begin
                    if (failure_count < REPORT_LIMIT)
                        $display("mismatch: expected pop %h status %0d occ %0d/%0d, got pop %h status %0d occ %0d/%0d",
                                 want.pop_value, want.status, want.occupancy_one,
                                 want.occupancy_two, res_if.pop_value, res_if.status,
                                 res_if.occupancy_one, res_if.occupancy_two);
                    failure_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Sequence the tests
    initial begin
        failure_count = 0;
        burst_left    = 0;
        hold_request  = 0;
        words_one     = 0;
        words_two     = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = '0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_ENQ_ONE;
        req_if.push_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_traffic();
        req_if.valid <= 1'b0;

        // drain, then allow for the output register latency
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (failure_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
